FILE: sv/svpid_pkg.sv
// shared types, widths and operation codes for the six-axis velocity pid
`default_nettype none
package svpid_pkg;

    localparam int NUM_AXES  = 6;
    localparam int AXIS_W    = 3;
    localparam int VAL_W     = 16;
    localparam int ERR_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 48;
    localparam int INTEG_W   = 40;
    localparam int OUT_W     = 32;
    localparam int MUL_A_W   = 21;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 58;
    localparam int LO_SPLIT  = 20;
    localparam int ROUND_SH  = 16;

    // accumulator operations of the shared multiply-add unit
    localparam logic [2:0] MAC_HOLD   = 3'd0;
    localparam logic [2:0] MAC_LOAD   = 3'd1;
    localparam logic [2:0] MAC_ACC    = 3'd2;
    localparam logic [2:0] MAC_ACC_HI = 3'd3;
    localparam logic [2:0] MAC_ROUND  = 3'd4;

    typedef struct packed {
        logic [2:0]                 op;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
        logic signed [ACC_W-1:0]    addend;
    } mac_ctl_t;

endpackage
`default_nettype wire

FILE: sv/svpid_mac.sv
// shared signed multiplier with a wide accumulator and rounding step
`default_nettype none
module svpid_mac (
    input  wire logic                           aclk,
    input  wire svpid_pkg::mac_ctl_t            ctl,
    output logic signed [svpid_pkg::ACC_W-1:0]  acc
);
    import svpid_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (ROUND_SH - 1);

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod     = ctl.a * ctl.b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_comb begin
        case (ctl.op)
            MAC_LOAD:   acc_next = ctl.addend + prod_ext;
            MAC_ACC:    acc_next = acc_reg + prod_ext;
            MAC_ACC_HI: acc_next = acc_reg + (prod_ext <<< LO_SPLIT);
            // floor((x + half) / 2^16)
            MAC_ROUND:  acc_next = (acc_reg + ROUND_HALF) >>> ROUND_SH;
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

FILE: sv/six_axis_velocity_pid.sv
// six-axis velocity pid: top level with sequencer, gain registers and integrals
// a valid axis's word passes integrate, clamp, ki low, ki high, round, kp and kd
// on the shared multiplier before its result enters the output register; an axis
// out of range goes straight there. s_tready drops while a word is in work, so no
// new word is taken before the last result is registered. aresetn (synchronous)
// clears gains, integrals and handshake state; no clearing pass is needed.
`default_nettype none
module six_axis_velocity_pid (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [2:0]                     cfg_addr,
    input  wire logic [svpid_pkg::CFG_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,  // desired, measured, accel, period
    input  wire logic [3:0]                     s_tuser,  // axis, setpoint_present
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [31:0]                         m_tdata,  // drive_value
    output logic [3:0]                          m_tuser   // axis_out, saturated
);
    import svpid_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INT   = 4'd1;
    localparam logic [3:0] ST_CLAMP = 4'd2;
    localparam logic [3:0] ST_KI_LO = 4'd3;
    localparam logic [3:0] ST_KI_HI = 4'd4;
    localparam logic [3:0] ST_ROUND = 4'd5;
    localparam logic [3:0] ST_KP    = 4'd6;
    localparam logic [3:0] ST_KD    = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic signed [ACC_W-1:0] INTEG_MAX =
        $signed({{(ACC_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] INTEG_MIN =
        $signed({{(ACC_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}});
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        $signed({{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] OUT_MIN =
        $signed({{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});

    logic [3:0]                 state_reg, state_next;
    logic [CFG_W-1:0]           gain_reg [NUM_AXES];
    logic signed [INTEG_W-1:0]  integ_reg [NUM_AXES];
    logic [AXIS_W-1:0]          axis_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    nacc_reg;
    logic [VAL_W-1:0]           dt_reg;
    logic                       sat_reg;
    logic                       bad_reg;
    logic                       m_tvalid_reg;
    logic [OUT_W-1:0]           m_data_reg;
    logic [3:0]                 m_user_reg;

    mac_ctl_t                   ctl;
    logic signed [ACC_W-1:0]    acc;

    logic                       s_accept;
    logic                       out_free;
    logic signed [ERR_W-1:0]    in_desired;
    logic signed [ERR_W-1:0]    in_meas;
    logic signed [ERR_W-1:0]    in_accel;
    logic [GAIN_W-1:0]          cur_kp, cur_ki, cur_kd;
    logic signed [INTEG_W-1:0]  cur_integ;
    logic signed [INTEG_W-1:0]  integ_clamped;
    logic                       integ_clip;
    logic [OUT_W-1:0]           drive_clamped;
    logic                       drive_clip;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_desired = s_tuser[3] ? ERR_W'($signed(s_tdata[15:0])) : '0;
    assign in_meas    = ERR_W'($signed(s_tdata[31:16]));
    assign in_accel   = ERR_W'($signed(s_tdata[47:32]));

    assign cur_kp    = gain_reg[axis_reg][15:0];
    assign cur_ki    = gain_reg[axis_reg][31:16];
    assign cur_kd    = gain_reg[axis_reg][47:32];
    assign cur_integ = integ_reg[axis_reg];

    always_comb begin
        integ_clip    = 1'b1;
        integ_clamped = INTEG_MAX[INTEG_W-1:0];
        if (acc > INTEG_MAX) begin
            integ_clamped = INTEG_MAX[INTEG_W-1:0];
        end else if (acc < INTEG_MIN) begin
            integ_clamped = INTEG_MIN[INTEG_W-1:0];
        end else begin
            integ_clip    = 1'b0;
            integ_clamped = acc[INTEG_W-1:0];
        end
    end

    always_comb begin
        drive_clip    = 1'b1;
        drive_clamped = OUT_MAX[OUT_W-1:0];
        if (acc > OUT_MAX) begin
            drive_clamped = OUT_MAX[OUT_W-1:0];
        end else if (acc < OUT_MIN) begin
            drive_clamped = OUT_MIN[OUT_W-1:0];
        end else begin
            drive_clip    = 1'b0;
            drive_clamped = acc[OUT_W-1:0];
        end
    end

    // operands for the shared multiplier, one step per state
    always_comb begin
        ctl.op     = MAC_HOLD;
        ctl.a      = '0;
        ctl.b      = '0;
        ctl.addend = '0;
        case (state_reg)
            ST_INT: begin
                ctl.op     = MAC_LOAD;
                ctl.a      = MUL_A_W'(err_reg);
                ctl.b      = $signed({1'b0, dt_reg});
                ctl.addend = ACC_W'(cur_integ);
            end
            ST_KI_LO: begin
                ctl.op = MAC_LOAD;
                ctl.a  = $signed({1'b0, cur_integ[LO_SPLIT-1:0]});
                ctl.b  = $signed({1'b0, cur_ki});
            end
            ST_KI_HI: begin
                ctl.op = MAC_ACC_HI;
                ctl.a  = MUL_A_W'($signed(cur_integ[INTEG_W-1:LO_SPLIT]));
                ctl.b  = $signed({1'b0, cur_ki});
            end
            ST_ROUND: begin
                ctl.op = MAC_ROUND;
            end
            ST_KP: begin
                ctl.op = MAC_ACC;
                ctl.a  = MUL_A_W'(err_reg);
                ctl.b  = $signed({1'b0, cur_kp});
            end
            ST_KD: begin
                ctl.op = MAC_ACC;
                ctl.a  = MUL_A_W'(nacc_reg);
                ctl.b  = $signed({1'b0, cur_kd});
            end
            default: begin
                ctl.op = MAC_HOLD;
            end
        endcase
    end

    svpid_mac u_mac (
        .aclk (aclk),
        .ctl  (ctl),
        .acc  (acc)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser[2:0] >= AXIS_W'(NUM_AXES)) ? ST_OUT : ST_INT;
                end
            end
            ST_INT:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_KI_LO;
            ST_KI_LO: state_next = ST_KI_HI;
            ST_KI_HI: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_KP;
            ST_KP:    state_next = ST_KD;
            ST_KD:    state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            axis_reg <= s_tuser[2:0];
            err_reg  <= in_desired - in_meas;
            nacc_reg <= -in_accel;
            dt_reg   <= s_tdata[63:48];
            bad_reg  <= (s_tuser[2:0] >= AXIS_W'(NUM_AXES));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else if (s_accept) begin
            sat_reg <= 1'b0;
        end else if (state_reg == ST_CLAMP) begin
            sat_reg <= integ_clip;
        end
    end

    // gains and integrals; a changed ki clears that axis's integral
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                gain_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_CLAMP) begin
                integ_reg[axis_reg] <= integ_clamped;
            end
            if (cfg_wr_en && (cfg_addr < AXIS_W'(NUM_AXES))) begin
                gain_reg[cfg_addr] <= cfg_wdata;
                if (cfg_wdata[31:16] != gain_reg[cfg_addr][31:16]) begin
                    integ_reg[cfg_addr] <= '0;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            if (bad_reg) begin
                m_data_reg <= '0;
                m_user_reg <= {1'b0, axis_reg};
            end else begin
                m_data_reg <= drive_clamped;
                m_user_reg <= {sat_reg | drive_clip, axis_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire
